### rtl/cfd_pkg.sv
`timescale 1ns / 1ps

package cfd_pkg;

	// input opcodes
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// frame status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_CRC_ERR = 3'd1;
	localparam logic [2:0] ST_BAD_END = 3'd2;
	localparam logic [2:0] ST_BAD_LEN = 3'd3;
	localparam logic [2:0] ST_TIMEOUT = 3'd4;

	// result kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_TIMEOUT_RELOAD = 2'd0;
	localparam logic [1:0] CFG_MAX_PAYLOAD    = 2'd1;
	localparam logic [1:0] CFG_CRC_POLY       = 2'd2;

	// framing bytes
	localparam logic [7:0] START_SHORT = 8'h02;
	localparam logic [7:0] START_LONG  = 8'h03;
	localparam logic [7:0] END_BYTE    = 8'h03;

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b0000001,
		PH_LEN_HI = 7'b0000010,
		PH_LEN_LO = 7'b0000100,
		PH_DATA   = 7'b0001000,
		PH_CRC_HI = 7'b0010000,
		PH_CRC_LO = 7'b0100000,
		PH_END    = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [15:0] timeout_reload;
		logic [10:0] max_payload;
		logic [15:0] crc_poly;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  status;
		logic [10:0] length;
	} result_t;

endpackage

### rtl/cfd_crc_byte.sv
`timescale 1ns / 1ps

// One byte of an MSB-first CRC-16 update.
module cfd_crc_byte (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	input  logic [15:0] poly,
	output logic [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ poly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

### rtl/cfd_payload_ram.sv
`timescale 1ns / 1ps

module cfd_payload_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/cfd_frame_ctrl.sv
`timescale 1ns / 1ps

// Frame phase sequencer, CRC accumulation and timeout counter.
module cfd_frame_ctrl #(
	parameter int DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [1:0]       opcode,
	input  logic [7:0]       data_byte,
	input  cfd_pkg::cfg_t    cfg,
	output logic             res_valid,
	output cfd_pkg::result_t res,
	output logic             wr_en,
	output logic [10:0]      wr_addr
);

	cfd_pkg::phase_t phase_q, phase_d;
	logic [15:0] frame_len_q, frame_len_d;
	logic [10:0] byte_cnt_q, byte_cnt_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] rx_crc_q, rx_crc_d;
	logic [15:0] tmo_q, tmo_d;
	logic [15:0] crc_next;
	logic [15:0] len_lo;
	logic [10:0] cnt_inc;
	logic [15:0] tmo_dec;

	cfd_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (data_byte),
		.poly    (cfg.crc_poly),
		.crc_out (crc_next)
	);

	assign len_lo  = {frame_len_q[15:8], data_byte};
	assign cnt_inc = byte_cnt_q + 11'd1;
	assign tmo_dec = (tmo_q != 16'd0) ? tmo_q - 16'd1 : 16'd0;

	assign wr_en   = step && opcode == cfd_pkg::OP_BYTE && phase_q == cfd_pkg::PH_DATA;
	assign wr_addr = byte_cnt_q;

	always_comb begin
		phase_d     = phase_q;
		frame_len_d = frame_len_q;
		byte_cnt_d  = byte_cnt_q;
		crc_d       = crc_q;
		rx_crc_d    = rx_crc_q;
		tmo_d       = tmo_q;
		res_valid   = 1'b0;
		res.kind    = cfd_pkg::KIND_STATUS;
		res.status  = cfd_pkg::ST_OK;
		res.length  = 11'd0;
		case (opcode)
			cfd_pkg::OP_BYTE: begin
				unique case (phase_q)
					cfd_pkg::PH_IDLE: begin
						if (data_byte == cfd_pkg::START_SHORT ||
							data_byte == cfd_pkg::START_LONG) begin
							phase_d     = (data_byte == cfd_pkg::START_SHORT) ?
								cfd_pkg::PH_LEN_LO : cfd_pkg::PH_LEN_HI;
							tmo_d       = cfg.timeout_reload;
							byte_cnt_d  = 11'd0;
							frame_len_d = 16'd0;
							crc_d       = 16'd0;
						end
					end
					cfd_pkg::PH_LEN_HI: begin
						frame_len_d = {data_byte, 8'h00};
						phase_d     = cfd_pkg::PH_LEN_LO;
						tmo_d       = cfg.timeout_reload;
					end
					cfd_pkg::PH_LEN_LO: begin
						frame_len_d = len_lo;
						if (len_lo != 16'd0 && len_lo <= {5'd0, cfg.max_payload} &&
							32'(len_lo) <= DEPTH) begin
							phase_d = cfd_pkg::PH_DATA;
							tmo_d   = cfg.timeout_reload;
						end else begin
							phase_d    = cfd_pkg::PH_IDLE;
							res_valid  = 1'b1;
							res.status = cfd_pkg::ST_BAD_LEN;
						end
					end
					cfd_pkg::PH_DATA: begin
						crc_d      = crc_next;
						byte_cnt_d = cnt_inc;
						if ({5'd0, cnt_inc} >= frame_len_q) begin
							phase_d = cfd_pkg::PH_CRC_HI;
						end
						tmo_d = cfg.timeout_reload;
					end
					cfd_pkg::PH_CRC_HI: begin
						rx_crc_d = {data_byte, 8'h00};
						phase_d  = cfd_pkg::PH_CRC_LO;
						tmo_d    = cfg.timeout_reload;
					end
					cfd_pkg::PH_CRC_LO: begin
						rx_crc_d = {rx_crc_q[15:8], data_byte};
						phase_d  = cfd_pkg::PH_END;
						tmo_d    = cfg.timeout_reload;
					end
					cfd_pkg::PH_END: begin
						phase_d    = cfd_pkg::PH_IDLE;
						res_valid  = 1'b1;
						res.length = frame_len_q[10:0];
						if (data_byte != cfd_pkg::END_BYTE) begin
							res.status = cfd_pkg::ST_BAD_END;
						end else if (crc_q == rx_crc_q) begin
							res.status = cfd_pkg::ST_OK;
						end else begin
							res.status = cfd_pkg::ST_CRC_ERR;
						end
					end
					default: begin
						phase_d = cfd_pkg::PH_IDLE;
					end
				endcase
			end
			cfd_pkg::OP_TICK: begin
				tmo_d = tmo_dec;
				if (tmo_dec == 16'd0 && phase_q != cfd_pkg::PH_IDLE) begin
					phase_d    = cfd_pkg::PH_IDLE;
					res_valid  = 1'b1;
					res.status = cfd_pkg::ST_TIMEOUT;
				end
			end
			cfd_pkg::OP_READ: begin
				res_valid = 1'b1;
				res.kind  = cfd_pkg::KIND_READ;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= cfd_pkg::PH_IDLE;
			frame_len_q <= 16'd0;
			byte_cnt_q  <= 11'd0;
			crc_q       <= 16'd0;
			rx_crc_q    <= 16'd0;
			tmo_q       <= 16'd0;
		end else if (step) begin
			phase_q     <= phase_d;
			frame_len_q <= frame_len_d;
			byte_cnt_q  <= byte_cnt_d;
			crc_q       <= crc_d;
			rx_crc_q    <= rx_crc_d;
			tmo_q       <= tmo_d;
		end
	end

endmodule

### rtl/crc_frame_receive_deframer.sv
`timescale 1ns / 1ps

// An accepted item is held in the input register until the output register is free or draining;
// any result it yields then enters the output register, which drives m_axis_tvalid.
// Throughput: one item per cycle while the output is not stalled; the byte-wide CRC update and
// the payload RAM port (one write or one registered read per cycle) set that figure.
// Reset: arst_n clears the frame sequencer, counters and handshake flags and loads the
// register defaults; the payload RAM is not cleared and holds garbage until written.
module crc_frame_receive_deframer #(
	parameter int PAYLOAD_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // data_byte[7:0], read_index[17:8], zero pad
	input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // frame_status[2:0], frame_bytes[13:3],
	                                   // read_data[21:14], zero pad
	output logic        m_axis_tuser,  // result_kind[0]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = $clog2(PAYLOAD_DEPTH);

	cfd_pkg::cfg_t cfg_q;

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [7:0]  byte_s1;
	logic [9:0]  idx_s1;

	logic             advance;
	logic             accept;
	logic             res_valid;
	cfd_pkg::result_t res;
	logic             wr_en;
	logic [10:0]      wr_addr;

	logic [AW+10:0]   waddr_ext;
	logic [AW+9:0]    raddr_ext;
	logic             rd_en;
	logic             in_range;
	logic [7:0]       rdata;

	logic             m_valid_q;
	cfd_pkg::result_t res_s2;
	logic             rd_ok_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_reload <= 16'd2;
			cfg_q.max_payload    <= 11'd1024;
			cfg_q.crc_poly       <= 16'h1021;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cfd_pkg::CFG_TIMEOUT_RELOAD: cfg_q.timeout_reload <= cfg_data;
				cfd_pkg::CFG_MAX_PAYLOAD:    cfg_q.max_payload    <= cfg_data[10:0];
				cfd_pkg::CFG_CRC_POLY:       cfg_q.crc_poly       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// the held item moves on once the output register is free or draining
	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= s_axis_tuser;
			byte_s1 <= s_axis_tdata[7:0];
			idx_s1  <= s_axis_tdata[17:8];
		end
	end

	cfd_frame_ctrl #(
		.DEPTH (PAYLOAD_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.opcode    (op_s1),
		.data_byte (byte_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr)
	);

	assign waddr_ext = (AW + 11)'(wr_addr);
	assign raddr_ext = (AW + 10)'(idx_s1);
	assign in_range  = 32'(idx_s1) < PAYLOAD_DEPTH;
	assign rd_en     = advance && op_s1 == cfd_pkg::OP_READ;

	cfd_payload_ram #(
		.DEPTH (PAYLOAD_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr_ext[AW-1:0]),
		.wdata (byte_s1),
		.re    (rd_en),
		.raddr (raddr_ext[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2   <= res;
			rd_ok_s2 <= (res.kind == cfd_pkg::KIND_READ) && in_range;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = res_s2.kind;
	assign m_axis_tdata  = {2'b00, (rd_ok_s2 ? rdata : 8'h00), res_s2.length, res_s2.status};

`ifndef SYNTH
	// read results never carry status or length
	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == cfd_pkg::KIND_READ |->
			m_axis_tdata[13:0] == 14'd0)
		else $error("read result with nonzero status or length");

	// status reports never carry read data
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == cfd_pkg::KIND_STATUS |->
			m_axis_tdata[21:14] == 8'd0)
		else $error("status report with nonzero read data");

	// aborted frames report zero length
	a_abort_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == cfd_pkg::KIND_STATUS &&
		(m_axis_tdata[2:0] == cfd_pkg::ST_BAD_LEN ||
		 m_axis_tdata[2:0] == cfd_pkg::ST_TIMEOUT) |->
			m_axis_tdata[13:3] == 11'd0)
		else $error("abort report with nonzero length");

	// a held item is not dropped while the output stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(op_s1) && $stable(byte_s1))
		else $error("input stage item lost during stall");
`endif

endmodule
